// ===== src/dns_query_packet_builder_assert.svh =====
// ----------------------------------------------------------------------------
// DNS query packet builder assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_PACKET_BUILDER_ASSERT_SVH
`define DNS_QUERY_PACKET_BUILDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DQPB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define DQPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define DQPB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define DQPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/dqpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query packet builder package
// Shared types, constants and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package dqpb_pkg;

	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int UC_ADDR_W = 5;

	typedef enum logic [1:0] {
		OP_HEADER,
		OP_CHAR,
		OP_END,
		OP_TRAILER
	} op_t;

	localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

	localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'h0000, 16'h0100, 16'h0001, 16'h0000,
		16'h0000, 16'h0000, 16'h0001, 16'h0001
	};

	// Byte index into the configuration space of the high byte of QTYPE.
	localparam logic [3:0] CFG_QTYPE_HI = 4'd12;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_CFG,
		SRC_LEN,
		SRC_MEM
	} src_t;

	typedef enum logic [1:0] {
		C_NONE,
		C_DISPATCH,
		C_EMPTY,
		C_LOOP
	} cond_t;

	typedef logic [UC_ADDR_W-1:0] uc_addr_t;

	localparam uc_addr_t UC_IDLE    = 5'd0;
	localparam uc_addr_t UC_HDR     = 5'd1;
	localparam uc_addr_t UC_HDR_END = 5'd12;
	localparam uc_addr_t UC_FLUSH   = 5'd13;
	localparam uc_addr_t UC_LOOP    = 5'd14;
	localparam uc_addr_t UC_TRL     = 5'd15;
	localparam uc_addr_t UC_TRL_END = 5'd19;

	typedef struct packed {
		cond_t      cond;
		src_t       src;
		logic [3:0] cfg_sel;
		logic       last;
		logic       fill_clr;
		uc_addr_t   next;
	} ucw_t;

	typedef struct packed {
		logic       emit;
		logic       last;
		src_t       src;
		logic [3:0] cfg_sel;
		logic       store;
		logic       ptr_clr;
		logic       ptr_inc;
		logic       fill_clr;
	} dp_ctrl_t;

	typedef struct packed {
		logic slot_free;
		logic fill_empty;
		logic at_end;
	} dp_stat_t;

	function automatic ucw_t uc_rom(input uc_addr_t addr);
		ucw_t w;
		w = '{cond: C_DISPATCH, src: SRC_ZERO, cfg_sel: 4'd0, last: 1'b0,
			fill_clr: 1'b0, next: UC_IDLE};
		case (addr) inside
			[UC_HDR:UC_HDR_END]: begin
				w = '{cond: C_NONE, src: SRC_CFG, cfg_sel: 4'(addr - UC_HDR),
					last: (addr == UC_HDR_END), fill_clr: 1'b0,
					next: (addr == UC_HDR_END) ? UC_IDLE : UC_ADDR_W'(addr + 5'd1)};
			end
			UC_FLUSH: begin
				w = '{cond: C_EMPTY, src: SRC_LEN, cfg_sel: 4'd0, last: 1'b0,
					fill_clr: 1'b0, next: UC_LOOP};
			end
			UC_LOOP: begin
				w = '{cond: C_LOOP, src: SRC_MEM, cfg_sel: 4'd0, last: 1'b0,
					fill_clr: 1'b0, next: UC_IDLE};
			end
			UC_TRL: begin
				w = '{cond: C_NONE, src: SRC_ZERO, cfg_sel: 4'd0, last: 1'b0,
					fill_clr: 1'b1, next: UC_ADDR_W'(UC_TRL + 5'd1)};
			end
			[UC_TRL+5'd1:UC_TRL_END]: begin
				w = '{cond: C_NONE, src: SRC_CFG,
					cfg_sel: 4'(addr - UC_TRL - 5'd1) + CFG_QTYPE_HI,
					last: (addr == UC_TRL_END), fill_clr: 1'b0,
					next: (addr == UC_TRL_END) ? UC_IDLE : UC_ADDR_W'(addr + 5'd1)};
			end
			default: begin
				w = '{cond: C_DISPATCH, src: SRC_ZERO, cfg_sel: 4'd0, last: 1'b0,
					fill_clr: 1'b0, next: UC_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/dns_query_packet_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query packet builder
// Encodes header, dotted name and question trailer of a DNS query message
// into one wire-format byte stream under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: name_char; tuser: op
// m_axis    out        tdata: out_byte; tlast: run_last; tuser: label_overflow
// cfg       in         cfg_index: register index; cfg_data: register value
//
// A name character is buffered; a header emits twelve bytes, a label its
// length byte and its characters, a trailer five bytes, at one byte per
// cycle via the output register while the output is not stalled. A dot or
// end of name with no buffered label emits no byte. Reset clears the label
// buffer fill, the overflow flag and the sequencer, and loads the register
// reset values. A stalled output holds the sequencer on its current step.
// ----------------------------------------------------------------------------
`include "dns_query_packet_builder_assert.svh"

module dns_query_packet_builder
	import dqpb_pkg::*;
#(
	parameter int LABEL_LIMIT = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] name_char
	input  logic [1:0]           s_axis_tuser,  // [1:0] op
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
	output logic                 m_axis_tlast,
	output logic [0:0]           m_axis_tuser,  // [0] label_overflow
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	dqpb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_char  (s_axis_tdata),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	dqpb_dp #(
		.LABEL_LIMIT (LABEL_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_char   (s_axis_tdata),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser[0])
	);

	`DQPB_ASSERT_IMPLIES(a_emit_slot, clk, arst_n, ctrl.emit, stat.slot_free)
	`DQPB_ASSERT_IMPLIES(a_store_quiet, clk, arst_n, ctrl.store, !ctrl.emit && s_axis_tready)
	`DQPB_ASSERT_NEXT(a_hdr_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_HEADER), !s_axis_tready)

endmodule

// ===== src/dqpb_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query packet builder sequencer
// Step counter over the microcode program; turns control words into
// datapath controls and decodes incoming items.
// ----------------------------------------------------------------------------
module dqpb_seq
	import dqpb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_op,
	input  logic [BYTE_W-1:0] in_char,
	input  dp_stat_t          stat,
	output dp_ctrl_t          ctrl
);

	uc_addr_t step_q;
	uc_addr_t step_d;
	ucw_t     cw;

	assign cw       = uc_rom(step_q);
	assign in_ready = (step_q == UC_IDLE);

	always_comb begin
		step_d       = step_q;
		ctrl         = '0;
		ctrl.src     = cw.src;
		ctrl.cfg_sel = cw.cfg_sel;
		case (cw.cond)
			C_DISPATCH: begin
				if (in_valid) begin
					case (op_t'(in_op))
						OP_HEADER: step_d = UC_HDR;
						OP_CHAR: begin
							if (in_char == DOT_CHAR) begin
								step_d = UC_FLUSH;
							end else begin
								ctrl.store = 1'b1;
							end
						end
						OP_END:     step_d = UC_FLUSH;
						OP_TRAILER: step_d = UC_TRL;
						default:    step_d = UC_IDLE;
					endcase
				end
			end
			C_EMPTY: begin
				if (stat.fill_empty) begin
					step_d = UC_IDLE;
				end else if (stat.slot_free) begin
					ctrl.emit    = 1'b1;
					ctrl.ptr_clr = 1'b1;
					step_d       = cw.next;
				end
			end
			C_LOOP: begin
				if (stat.slot_free) begin
					ctrl.emit = 1'b1;
					ctrl.last = stat.at_end;
					if (stat.at_end) begin
						ctrl.fill_clr = 1'b1;
						ctrl.ptr_clr  = 1'b1;
						step_d        = cw.next;
					end else begin
						ctrl.ptr_inc = 1'b1;
					end
				end
			end
			default: begin
				if (stat.slot_free) begin
					ctrl.emit     = 1'b1;
					ctrl.last     = cw.last;
					ctrl.fill_clr = cw.fill_clr;
					step_d        = cw.next;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= UC_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== src/dqpb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query packet builder datapath
// Configuration registers, label buffer, fill and read pointers, output
// byte selection and the output register.
// ----------------------------------------------------------------------------
module dqpb_dp
	import dqpb_pkg::*;
#(
	parameter int LABEL_LIMIT = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [BYTE_W-1:0]    in_char,
	input  dp_ctrl_t             ctrl,
	output dp_stat_t             stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_last,
	output logic                 out_ovf
);

	localparam int FILL_W = $clog2(LABEL_LIMIT + 1);
	localparam int ADDR_W = (LABEL_LIMIT > 1) ? $clog2(LABEL_LIMIT) : 1;

	logic [CFG_W-1:0]  regs_q [NUM_REGS];
	logic [BYTE_W-1:0] mem [LABEL_LIMIT];
	logic [BYTE_W-1:0] rdata_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] ptr_q;
	logic [FILL_W-1:0] ptr_d;
	logic [FILL_W-1:0] ptr_nx;
	logic              ovf_q;
	logic              can_store;
	logic [CFG_W-1:0]  cfg_word;
	logic [BYTE_W-1:0] cfg_byte;
	logic [BYTE_W-1:0] sel_byte;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_ovf_q;

	assign ptr_nx    = ptr_q + FILL_W'(1);
	assign can_store = (fill_q < FILL_W'(LABEL_LIMIT));
	assign cfg_word  = regs_q[ctrl.cfg_sel[3:1]];
	assign cfg_byte  = ctrl.cfg_sel[0] ? cfg_word[7:0] : cfg_word[15:8];

	always_comb begin
		if (ctrl.ptr_clr) begin
			ptr_d = '0;
		end else if (ctrl.ptr_inc) begin
			ptr_d = ptr_nx;
		end else begin
			ptr_d = ptr_q;
		end
	end

	always_comb begin
		case (ctrl.src)
			SRC_CFG: sel_byte = cfg_byte;
			SRC_LEN: sel_byte = BYTE_W'(fill_q);
			SRC_MEM: sel_byte = rdata_q;
			default: sel_byte = '0;
		endcase
	end

	assign stat.slot_free  = !out_valid_q || out_ready;
	assign stat.fill_empty = (fill_q == '0);
	assign stat.at_end     = (ptr_nx == fill_q);

	always_ff @(posedge clk) begin
		if (ctrl.store && can_store) begin
			mem[fill_q[ADDR_W-1:0]] <= in_char;
		end
		rdata_q <= mem[ptr_d[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q      <= REG_RESET;
			fill_q      <= '0;
			ptr_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
				regs_q[cfg_index[2:0]] <= cfg_data;
			end
			if (ctrl.fill_clr) begin
				fill_q <= '0;
			end else if (ctrl.store && can_store) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (ctrl.store && !can_store) begin
				ovf_q <= 1'b1;
			end
			ptr_q <= ptr_d;
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_byte_q <= sel_byte;
			out_last_q <= ctrl.last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule
